@@ rtl/core/mwnc_pkg.sv @@
package mwnc_pkg;

   // sample, magnitude and register formats
   localparam int ACC_W     = 13;
   localparam int MAG_W     = 18;
   localparam int D2_W      = 28;
   localparam int RAD_SHIFT = 8;
   localparam int RAD_W     = D2_W + RAD_SHIFT;
   localparam int ACT_W     = 3;
   localparam int CSR_N     = 8;
   localparam int CSR_IDX_W = 8;
   localparam int DIST_W    = 2 * MAG_W + 1;

   typedef logic [MAG_W-1:0] q4_type;

   // deviation above 1000.0 in Q14.4 blocks a decision
   localparam q4_type DEV_LIMIT = 18'd16000;

   // centroid reset values, deviation then mean for each class
   localparam q4_type CSR_RESET [CSR_N] = '{
      18'd48, 18'd35, 18'd480, 18'd592, 18'd1088, 18'd1328, 18'd1536, 18'd544
   };

   localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_SQ       = 10'b00_0000_0010,
      ST_SQRT_MAG = 10'b00_0000_0100,
      ST_UPD      = 10'b00_0000_1000,
      ST_NMUL     = 10'b00_0001_0000,
      ST_NUM      = 10'b00_0010_0000,
      ST_VDIV     = 10'b00_0100_0000,
      ST_SQRT_DEV = 10'b00_1000_0000,
      ST_CLS      = 10'b01_0000_0000,
      ST_OUT      = 10'b10_0000_0000
   } state_type;

endpackage

@@ rtl/core/mwnc_ram.sv @@
module mwnc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mwnc_sqrt.sv @@
module mwnc_sqrt #(
   parameter int RAD_W = 36
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RAD_W-1:0]   radicand,
   output logic               done,
   output logic [RAD_W/2-1:0] root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W);
   localparam int REM_W  = ROOT_W + 2;
   localparam int TRY_W  = REM_W + 2;

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [TRY_W-1:0]  rem_sh;
   logic [TRY_W-1:0]  trial;
   logic [TRY_W-1:0]  rem_sub;
   logic              fits;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {{(TRY_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
      fits    = (rem_sh >= trial);
      rem_sub = rem_sh - trial;
   end

   // sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one root bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ rtl/core/mwnc_div.sv @@
module mwnc_div #(
   parameter int DVD_W = 25,
   parameter int DSR_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic [DVD_W-1:0] q_ff;
   logic [DSR_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DSR_W:0]   rem_sh;
   logic [DSR_W:0]   rem_sub;
   logic             fits;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      rem_sh  = {rem_ff, q_ff[DVD_W-1]};
      fits    = (rem_sh >= {1'b0, divisor});
      rem_sub = rem_sh - {1'b0, divisor};
   end

   // sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one quotient bit per cycle, dividend shifts out as quotient shifts in
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DVD_W-2:0], fits};
         rem_ff <= fits ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ rtl/core/motion_window_nearest_centroid.sv @@
// Activity classifier over a sliding window of motion magnitudes. Each item is one
// three-axis sample; the block forms the length of the change from the previous sample
// (Q14.4), keeps the last WINDOW_SAMPLES-1 lengths, and returns one result per item:
// window mean, standard deviation, and the nearest of four (deviation, mean) centroids
// unless the deviation exceeds 1000.0, in which case the centroid search is skipped. Items
// are handled one at a time, and a finished result waits in the output step until the
// output register is free or rsp_ready is high. The default window is 81 samples. Most
// of the work is the bit-serial divide of the variance numerator by the squared window
// length, one quotient bit per cycle, plus two passes of the shared serial square root.
// A finished result is held in the output register while the next item is taken.
// Centroid registers are to be written through the csr port only while the block is
// idle; the block itself does not enforce this. Indexes beyond 7 are ignored.
module motion_window_nearest_centroid #(
   parameter int WINDOW_SAMPLES = 81
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mwnc_pkg::ACC_W-1:0]    req_accel_x,
   input  logic signed [mwnc_pkg::ACC_W-1:0]    req_accel_y,
   input  logic signed [mwnc_pkg::ACC_W-1:0]    req_accel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mwnc_pkg::ACT_W-1:0]           rsp_activity,
   output logic                                 rsp_activity_changed,
   output logic                                 rsp_gated_out,
   output logic [mwnc_pkg::MAG_W-1:0]           rsp_window_mean,
   output logic [mwnc_pkg::MAG_W-1:0]           rsp_window_dev,
   input  logic                                 csr_we,
   input  logic [mwnc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mwnc_pkg::MAG_W-1:0]           csr_wdata
);

   import mwnc_pkg::*;

   localparam int RING_LEN = WINDOW_SAMPLES - 1;
   localparam int IDX_W    = $clog2(RING_LEN);
   localparam int N_W      = $clog2(RING_LEN + 1);
   localparam int SUM_W    = MAG_W + IDX_W;
   localparam int SQS_W    = 2 * MAG_W + IDX_W;
   localparam int NUM_W    = SQS_W + N_W;
   localparam int NN_W     = 2 * N_W;
   localparam int PROD_W   = 2 * SUM_W;
   localparam int STEP_W   = 4;
   localparam logic [N_W-1:0]  RING_N  = N_W'(RING_LEN);
   localparam logic [NN_W-1:0] RING_NN = NN_W'(RING_LEN * RING_LEN);

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]         k_ff, k_in;

   logic signed [ACC_W-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [ACC_W-1:0]   dx_ff, dy_ff, dz_ff;
   logic [D2_W-1:0]    d2_ff;
   logic [D2_W-1:0]    d2_nx;

   logic [SUM_W-1:0]   mul_a, mul_b;
   logic               mul_en;
   logic [PROD_W-1:0]  mul_ff;

   logic [IDX_W-1:0]   ptr_ff;
   logic [RING_LEN-1:0] valid_ff;
   logic [MAG_W-1:0]   ram_rdata;
   logic [MAG_W-1:0]   old_mag;
   logic [MAG_W-1:0]   old_ff;
   logic               ram_we;
   logic [SUM_W-1:0]   sum_ff;
   logic [SQS_W-1:0]   sqs_ff;

   logic [NUM_W-1:0]   shv_ff, prod_ff, num_nx;
   logic [N_W-1:0]     nsh_ff;

   logic               sq_start, sq_done;
   logic [RAD_W-1:0]   sq_rad;
   logic [MAG_W-1:0]   sq_root;
   logic               md_start;
   logic [SUM_W-1:0]   mean_q;
   logic               vd_start, vd_done;
   logic [NUM_W-1:0]   var_q;

   q4_type             cent_ff [CSR_N];
   logic [MAG_W-1:0]   feat, cent_sel, cls_diff;
   logic [DIST_W-1:0]  acc_ff, min_ff, dist_sum;
   logic [1:0]         best_ff;
   logic               tie_ff, gated_ff;
   logic [ACT_W-1:0]   cur_ff, new_act;
   logic               accept, out_load;

   logic               rsp_valid_ff, rsp_changed_ff, rsp_gated_ff;
   logic [ACT_W-1:0]   rsp_act_ff;
   logic [MAG_W-1:0]   rsp_mean_ff, rsp_dev_ff;

   function automatic logic [ACC_W-1:0] abs_diff(input logic signed [ACC_W-1:0] a,
                                                 input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] d;
      d = {a[ACC_W-1], a} - {b[ACC_W-1], b};
      return d[ACC_W] ? ACC_W'(-d) : ACC_W'(d);
   endfunction

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // old ring entry reads as zero until written
   assign old_mag = valid_ff[ptr_ff] ? ram_rdata : '0;
   assign ram_we  = (state_ff == ST_UPD) && (step_ff == STEP_W'(0));
   assign d2_nx   = d2_ff + mul_ff[D2_W-1:0];

   // variance numerator, clamped at zero, fed straight into the divider
   assign num_nx  = (prod_ff > NUM_W'(mul_ff)) ? (prod_ff - NUM_W'(mul_ff)) : '0;

   // shared serial units
   assign sq_start = ((state_ff == ST_SQ) && (step_ff == STEP_W'(3)))
                     || ((state_ff == ST_VDIV) && vd_done);
   assign sq_rad   = (state_ff == ST_SQ) ? {d2_nx, RAD_SHIFT'(0)} : var_q[RAD_W-1:0];
   assign md_start = (state_ff == ST_UPD) && (step_ff == STEP_W'(2));
   assign vd_start = (state_ff == ST_NUM);

   mwnc_ram #(.WIDTH(MAG_W), .DEPTH(RING_LEN)) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ptr_ff),
      .wr_data(sq_root),
      .rd_en  (accept),
      .rd_addr(ptr_ff),
      .rd_data(ram_rdata)
   );

   mwnc_sqrt #(.RAD_W(RAD_W)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .radicand(sq_rad),
      .done    (sq_done),
      .root    (sq_root)
   );

   mwnc_div #(.DVD_W(SUM_W), .DSR_W(N_W)) u_mean_div (
      .clock   (clock),
      .reset   (reset),
      .start   (md_start),
      .dividend(sum_ff),
      .divisor (RING_N),
      .done    (),
      .quotient(mean_q)
   );

   mwnc_div #(.DVD_W(NUM_W), .DSR_W(NN_W)) u_var_div (
      .clock   (clock),
      .reset   (reset),
      .start   (vd_start),
      .dividend(num_nx),
      .divisor (RING_NN),
      .done    (vd_done),
      .quotient(var_q)
   );

   // select centroid and feature for the distance terms
   always_comb begin
      feat     = step_ff[0] ? mean_q[MAG_W-1:0] : sq_root;
      cent_sel = cent_ff[{k_ff, step_ff[0]}];
      cls_diff = (feat > cent_sel) ? (feat - cent_sel) : (cent_sel - feat);
      dist_sum = acc_ff + DIST_W'(mul_ff[2*MAG_W-1:0]);
      new_act  = (!gated_ff && !tie_ff) ? (ACT_W'(best_ff) + 1'b1) : cur_ff;
   end

   // multiplier operand selection
   always_comb begin
      mul_a  = '0;
      mul_en = 1'b0;
      case (state_ff)
         ST_SQ: begin
            mul_en = (step_ff < STEP_W'(3));
            case (step_ff)
               STEP_W'(0): mul_a = SUM_W'(dx_ff);
               STEP_W'(1): mul_a = SUM_W'(dy_ff);
               default:    mul_a = SUM_W'(dz_ff);
            endcase
         end
         ST_UPD: begin
            mul_en = (step_ff < STEP_W'(3));
            case (step_ff)
               STEP_W'(0): mul_a = SUM_W'(sq_root);
               STEP_W'(1): mul_a = SUM_W'(old_ff);
               default:    mul_a = sum_ff;
            endcase
         end
         ST_CLS: begin
            mul_en = (step_ff < STEP_W'(2));
            mul_a  = SUM_W'(cls_diff);
         end
         default: mul_a = '0;
      endcase
      mul_b = mul_a;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 1'b1;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) state_in = ST_SQ;
         end
         ST_SQ: begin
            if (step_ff == STEP_W'(3)) begin
               state_in = ST_SQRT_MAG;
               step_in  = '0;
            end
         end
         ST_SQRT_MAG: begin
            step_in = '0;
            if (sq_done) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (step_ff == STEP_W'(3)) begin
               state_in = ST_NMUL;
               step_in  = '0;
            end
         end
         ST_NMUL: begin
            if (step_ff == STEP_W'(N_W - 1)) begin
               state_in = ST_NUM;
               step_in  = '0;
            end
         end
         ST_NUM: begin
            state_in = ST_VDIV;
            step_in  = '0;
         end
         ST_VDIV: begin
            step_in = '0;
            if (vd_done) state_in = ST_SQRT_DEV;
         end
         ST_SQRT_DEV: begin
            step_in = '0;
            k_in    = '0;
            if (sq_done) state_in = (sq_root > DEV_LIMIT) ? ST_OUT : ST_CLS;
         end
         ST_CLS: begin
            if (step_ff == STEP_W'(2)) begin
               step_in = '0;
               k_in    = k_ff + 1'b1;
               if (k_ff == 2'd3) state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            step_in = '0;
            if (out_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         k_ff         <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         sum_ff       <= '0;
         sqs_ff       <= '0;
         cur_ff       <= ACT_NONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CSR_N; i++) cent_ff[i] <= CSR_RESET[i];
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         if (csr_we && (csr_index < CSR_IDX_W'(CSR_N))) begin
            cent_ff[csr_index[$clog2(CSR_N)-1:0]] <= csr_wdata;
         end
         if (accept) begin
            prev_x_ff <= req_accel_x;
            prev_y_ff <= req_accel_y;
            prev_z_ff <= req_accel_z;
         end
         // replace the oldest length and roll the sums
         if (state_ff == ST_UPD) begin
            case (step_ff)
               STEP_W'(0): begin
                  valid_ff[ptr_ff] <= 1'b1;
                  sum_ff <= sum_ff - SUM_W'(old_mag) + SUM_W'(sq_root);
               end
               STEP_W'(1): sqs_ff <= sqs_ff + SQS_W'(mul_ff[2*MAG_W-1:0]);
               STEP_W'(2): begin
                  sqs_ff <= sqs_ff - SQS_W'(mul_ff[2*MAG_W-1:0]);
                  ptr_ff <= (ptr_ff == IDX_W'(RING_LEN - 1)) ? '0 : ptr_ff + 1'b1;
               end
               default: ;
            endcase
         end
         if (out_load) begin
            cur_ff       <= new_act;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (mul_en) mul_ff <= mul_a * mul_b;
      if (accept) begin
         dx_ff <= abs_diff(req_accel_x, prev_x_ff);
         dy_ff <= abs_diff(req_accel_y, prev_y_ff);
         dz_ff <= abs_diff(req_accel_z, prev_z_ff);
      end
      case (state_ff)
         ST_SQ: begin
            if (step_ff == STEP_W'(1)) d2_ff <= mul_ff[D2_W-1:0];
            if (step_ff == STEP_W'(2)) d2_ff <= d2_nx;
         end
         ST_UPD: begin
            if (step_ff == STEP_W'(0)) old_ff <= old_mag;
            if (step_ff == STEP_W'(3)) begin
               shv_ff  <= NUM_W'(sqs_ff);
               prod_ff <= '0;
               nsh_ff  <= RING_N;
            end
         end
         // window length times the square sum, one bit of the length per cycle
         ST_NMUL: begin
            if (nsh_ff[0]) prod_ff <= prod_ff + shv_ff;
            shv_ff <= shv_ff << 1;
            nsh_ff <= nsh_ff >> 1;
         end
         ST_SQRT_DEV: begin
            gated_ff <= (sq_root > DEV_LIMIT);
            tie_ff   <= 1'b0;
         end
         // track the unique nearest centroid
         ST_CLS: begin
            if (step_ff == STEP_W'(1)) acc_ff <= DIST_W'(mul_ff[2*MAG_W-1:0]);
            if (step_ff == STEP_W'(2)) begin
               if ((k_ff == 2'd0) || (dist_sum < min_ff)) begin
                  min_ff  <= dist_sum;
                  best_ff <= k_ff;
                  tie_ff  <= 1'b0;
               end else if (dist_sum == min_ff) begin
                  tie_ff <= 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_act_ff     <= new_act;
         rsp_changed_ff <= (new_act != cur_ff);
         rsp_gated_ff   <= gated_ff;
         rsp_mean_ff    <= mean_q[MAG_W-1:0];
         rsp_dev_ff     <= sq_root;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_activity         = rsp_act_ff;
   assign rsp_activity_changed = rsp_changed_ff;
   assign rsp_gated_out        = rsp_gated_ff;
   assign rsp_window_mean      = rsp_mean_ff;
   assign rsp_window_dev       = rsp_dev_ff;

   ap_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   ap_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= IDX_W'(RING_LEN - 1))
      else $error("ring pointer beyond window");

   ap_gated_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_gated_ff && rsp_changed_ff))
      else $error("gated item changed the activity");

   ap_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_SQRT_MAG || state_ff == ST_SQRT_DEV))
      else $error("square root finished outside a waiting step");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import mwnc_pkg::*;

   localparam int RING_LEN    = 80;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int TAIL_CYCLES = 200;

   typedef logic signed [ACC_W-1:0] accel_type;

   typedef struct {
      logic [ACT_W-1:0] activity;
      logic             changed;
      logic             gated;
      logic [MAG_W-1:0] mean;
      logic [MAG_W-1:0] dev;
   } activity_result_type;

   // Scoreboard: tracks the window statistics and the class decision
   class activity_scoreboard_type;
      q4_type              centroid [CSR_N];
      accel_type           last_x, last_y, last_z;
      longint unsigned     lengths [RING_LEN];
      int                  slot;
      longint unsigned     len_sum, len_sq_sum;
      logic [ACT_W-1:0]    cur_class;
      activity_result_type awaited [$];
      int                  errors;

      function new();
         for (int i = 0; i < CSR_N; i++) centroid[i] = CSR_RESET[i];
         last_x = '0;
         last_y = '0;
         last_z = '0;
         foreach (lengths[i]) lengths[i] = 0;
         slot = 0;
         len_sum = 0;
         len_sq_sum = 0;
         cur_class = ACT_NONE;
         errors = 0;
      endfunction

      function void write_centroid(int idx, q4_type value);
         if (idx < CSR_N) centroid[idx] = value;
      endfunction

      // floor square root, one result bit per pass
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root, probe;
         root = 0;
         for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= v) root = probe;
         end
         return root;
      endfunction

      function longint unsigned dist_sq(longint unsigned a, longint unsigned b);
         longint unsigned d;
         d = (a > b) ? a - b : b - a;
         return d * d;
      endfunction

      // work out the result of an accepted sample
      function void note_sample(accel_type x, accel_type y, accel_type z);
         longint signed       dx, dy, dz;
         longint unsigned     len, gone, mean, dev, num, sq;
         longint unsigned     cdist [4];
         activity_result_type r;
         int                  pick;
         bit                  best;
         dx = longint'(x) - longint'(last_x);
         dy = longint'(y) - longint'(last_y);
         dz = longint'(z) - longint'(last_z);
         len = floor_root(longint'(dx * dx + dy * dy + dz * dz) << 8);
         last_x = x;
         last_y = y;
         last_z = z;
         gone = lengths[slot];
         lengths[slot] = len;
         slot = (slot + 1 >= RING_LEN) ? 0 : slot + 1;
         len_sum = len_sum - gone + len;
         len_sq_sum = len_sq_sum - gone * gone + len * len;
         mean = len_sum / RING_LEN;
         num = RING_LEN * len_sq_sum;
         sq = len_sum * len_sum;
         num = (num > sq) ? num - sq : 0;
         dev = floor_root(num / (RING_LEN * RING_LEN));
         r.changed = 1'b0;
         r.gated = 1'b0;
         if (dev > DEV_LIMIT) begin
            r.gated = 1'b1;
         end else begin
            for (int k = 0; k < 4; k++)
               cdist[k] = dist_sq(dev, centroid[2*k]) + dist_sq(mean, centroid[2*k+1]);
            pick = -1;
            // strictly nearest centroid only; a tie keeps the class
            for (int k = 0; k < 4; k++) begin
               best = 1;
               for (int j = 0; j < 4; j++)
                  if (j != k && !(cdist[k] < cdist[j])) best = 0;
               if (best && pick < 0) pick = k;
            end
            if (pick >= 0) begin
               if (ACT_W'(pick + 1) != cur_class) r.changed = 1'b1;
               cur_class = ACT_W'(pick + 1);
            end
         end
         r.activity = cur_class;
         r.mean = mean[MAG_W-1:0];
         r.dev = dev[MAG_W-1:0];
         awaited.push_back(r);
      endfunction

      function void check_result(activity_result_type got);
         activity_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result with nothing awaited (activity %0d)", $time, got.activity);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.activity !== want.activity) begin
            $display("%0t: activity expected %0d actual %0d", $time, want.activity,
                     got.activity);
            errors++;
         end
         if (got.changed !== want.changed) begin
            $display("%0t: activity_changed expected %0d actual %0d", $time, want.changed,
                     got.changed);
            errors++;
         end
         if (got.gated !== want.gated) begin
            $display("%0t: gated_out expected %0d actual %0d", $time, want.gated, got.gated);
            errors++;
         end
         if (got.mean !== want.mean) begin
            $display("%0t: window_mean expected %0d actual %0d", $time, want.mean, got.mean);
            errors++;
         end
         if (got.dev !== want.dev) begin
            $display("%0t: window_dev expected %0d actual %0d", $time, want.dev, got.dev);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   accel_type            req_accel_x = '0;
   accel_type            req_accel_y = '0;
   accel_type            req_accel_z = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ACT_W-1:0]     rsp_activity;
   logic                 rsp_activity_changed;
   logic                 rsp_gated_out;
   logic [MAG_W-1:0]     rsp_window_mean;
   logic [MAG_W-1:0]     rsp_window_dev;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MAG_W-1:0]     csr_wdata = '0;

   activity_scoreboard_type sb = new();
   int                      cycle_count = 0;
   int                      hold_cycles = 0;
   int                      burst_left = 0;
   accel_type               walk_x = '0, walk_y = '0, walk_z = '0;

   motion_window_nearest_centroid dut (.*);

   always #2 clock = ~clock;

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall pattern; a hold-off overrides it
   always @(posedge clock) begin
      int rx_mode;
      if (cycle_count % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            0, 1: begin
               rsp_ready <= 1'b1;
            end
            2: begin
               rsp_ready <= $urandom_range(0, 1);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 4) == 0);
            end
         endcase
      end
   end

   // check every accepted result
   always @(posedge clock) begin
      activity_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.activity = rsp_activity;
         got.changed = rsp_activity_changed;
         got.gated = rsp_gated_out;
         got.mean = rsp_window_mean;
         got.dev = rsp_window_dev;
         sb.check_result(got);
      end
   end

   // offer one item and hold it until accepted; bursts end with a random gap
   task automatic send_sample(accel_type x, accel_type y, accel_type z);
      int gap;
      req_valid <= 1'b1;
      req_accel_x <= x;
      req_accel_y <= y;
      req_accel_z <= z;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(x, y, z);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 20);
         gap = $urandom_range(0, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // pause until every awaited result has come, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(int idx, q4_type value);
      csr_we <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= value;
      @(posedge clock);
      sb.write_centroid(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic accel_type clamp_step(accel_type v, int span);
      int n;
      n = int'(v) + $urandom_range(0, 2 * span) - span;
      if (n > 4095) n = 4095;
      if (n < -4096) n = -4096;
      return accel_type'(n);
   endfunction

   // smooth motion at a chosen step size, with some raw noise mixed in
   task automatic random_motion(int count);
      int span, seg_left;
      int spans [6] = '{0, 2, 30, 80, 300, 4000};
      seg_left = 0;
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            span = spans[$urandom_range(0, 5)];
            seg_left = $urandom_range(20, 200);
         end
         seg_left--;
         if ($urandom_range(0, 99) < 15) begin
            walk_x = accel_type'($urandom);
            walk_y = accel_type'($urandom);
            walk_z = accel_type'($urandom);
         end else begin
            walk_x = clamp_step(walk_x, span);
            walk_y = clamp_step(walk_y, span);
            walk_z = clamp_step(walk_z, span);
         end
         send_sample(walk_x, walk_y, walk_z);
      end
   endtask

   initial begin
      q4_type regs [CSR_N];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, still input, full swings to trip the limit
      send_sample(13'sd0, 13'sd0, 13'sd0);
      send_sample(-13'sd4096, -13'sd4096, -13'sd4096);
      send_sample(13'sd4095, 13'sd4095, 13'sd4095);
      send_sample(13'sd4095, -13'sd4096, 13'sd0);
      for (int i = 0; i < 6; i++) send_sample(13'sd100, 13'sd100, 13'sd100);
      for (int i = 0; i < 6; i++)
         if (i % 2 == 0) send_sample(13'sd4095, -13'sd4096, 13'sd4095);
         else send_sample(-13'sd4096, 13'sd4095, -13'sd4096);
      drain();

      // every centroid equal: always a tie, class must hold
      for (int i = 0; i < CSR_N; i++) write_reg(i, 18'd0);
      write_reg(200, 18'h3FFFF);
      for (int i = 0; i < 6; i++) send_sample(13'sd7, 13'sd7, 13'sd7);

      // long receiver hold-off while the sender keeps offering items
      drain();
      for (int i = 0; i < CSR_N; i++) write_reg(i, CSR_RESET[i]);
      hold_cycles = 1500;
      burst_left = 40;
      random_motion(30);

      // phases with different centroid settings, extremes among them
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         for (int i = 0; i < CSR_N; i++) begin
            case (ph)
               0: begin
                  regs[i] = 18'h3FFFF;
               end
               1: begin
                  regs[i] = (i % 2 == 0) ? 18'h3FFFF : 18'd0;
               end
               2: begin
                  regs[i] = CSR_RESET[CSR_N-1-i];
               end
               default: begin
                  regs[i] = $urandom_range(0, 3) == 0 ? q4_type'($urandom)
                                                      : q4_type'($urandom_range(0, 2500));
               end
            endcase
            write_reg(i, regs[i]);
         end
         write_reg($urandom_range(CSR_N, 255), q4_type'($urandom));
         random_motion(ph < 3 ? 150 : 265);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
